>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define PPT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ppt assertion failed");

// Same, with a caller-supplied message.
`define PPT_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

>>> sv/ppt_pkg.sv
// Shared constants, types and helpers of the planar pose transform.
package ppt_pkg;

    localparam int SQ_STEPS = 32;   // one root bit per stage
    localparam int DV_STEPS = 30;   // one quotient bit per stage
    localparam int LATENCY  = SQ_STEPS + DV_STEPS + 10;

    localparam logic [2:0] CFG_ROT_COS  = 3'd0;
    localparam logic [2:0] CFG_ROT_SIN  = 3'd1;
    localparam logic [2:0] CFG_HALF_COS = 3'd2;
    localparam logic [2:0] CFG_HALF_SIN = 3'd3;
    localparam logic [2:0] CFG_SHIFT_X  = 3'd4;
    localparam logic [2:0] CFG_SHIFT_Y  = 3'd5;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;
    localparam logic signed [63:0] RND_Q30 = 64'sh0000_0000_2000_0000;

    typedef struct packed {
        logic            vld;
        logic            quat;
        logic            zero;
        logic [3:0]      neg;
        logic [3:0][31:0] pass;
    } t_side;

    // Clamp a coefficient to +-1.0 in Q1.30.
    function automatic logic signed [31:0] sat_coef(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < NEG_ONE_Q30) begin
            r = NEG_ONE_Q30;
        end
        return r;
    endfunction

    // Saturate a 35-bit signed sum to 32 bits.
    function automatic logic [31:0] sat35(input logic [34:0] v);
        logic [31:0] r;
        r = v[31:0];
        if (!((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111))) begin
            r = v[34] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return r;
    endfunction

endpackage

>>> sv/planar_pose_transform.sv
// Top level of the planar pose transform pipeline.
//
// Usage:
//   Items enter on start/busy: an item is taken at a rising edge with start
//   high and busy low. cmd 0 rotates the point (comp_a, comp_b) by the
//   configured angle and adds the Q16.16 offsets, saturating to 32 bits.
//   cmd 1 premultiplies the Q2.29 quaternion by the yaw quaternion and
//   normalizes it; an all-zero product returns the input with zero_norm set.
//   Results leave on o_valid for exactly one cycle, in item order. The
//   receiver cannot stall, so the pipe advances every cycle and never holds
//   an item back. Throughput is one item per cycle while busy is low: every
//   stage is a plain register stage. The latency is set by the bit-serial
//   square root (32 stages) and the restoring divider (30 stages) that follow
//   the multiply/normalize front.
//   Configuration uses i_cfg_valid/o_cfg_ready; ready is always high, so a
//   write lands on every valid cycle. Coefficients clamp to +-1.0 on write,
//   unknown indexes are dropped. Write registers only while idle.
//   Reset (synchronous, active low) restores the default registers, flushes
//   all valid bits and holds busy high for the cycle after reset.
module planar_pose_transform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic signed [31:0] i_comp_a,
    input  logic signed [31:0] i_comp_b,
    input  logic signed [31:0] i_comp_c,
    input  logic signed [31:0] i_comp_d,
    output logic               o_valid,
    output logic signed [31:0] o_res_a,
    output logic signed [31:0] o_res_b,
    output logic signed [31:0] o_res_c,
    output logic signed [31:0] o_res_d,
    output logic               o_zero_norm,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int SQ = ppt_pkg::SQ_STEPS;
    localparam int DV = ppt_pkg::DV_STEPS;

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_rot_cos, r_rot_sin, r_half_cos, r_half_sin;
    logic signed [31:0] r_shift_x, r_shift_y;
    logic               r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_cos  <= ppt_pkg::ONE_Q30;
            r_rot_sin  <= '0;
            r_half_cos <= ppt_pkg::ONE_Q30;
            r_half_sin <= '0;
            r_shift_x  <= '0;
            r_shift_y  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppt_pkg::CFG_ROT_COS:  r_rot_cos  <= ppt_pkg::sat_coef($signed(i_cfg_data));
                ppt_pkg::CFG_ROT_SIN:  r_rot_sin  <= ppt_pkg::sat_coef($signed(i_cfg_data));
                ppt_pkg::CFG_HALF_COS: r_half_cos <= ppt_pkg::sat_coef($signed(i_cfg_data));
                ppt_pkg::CFG_HALF_SIN: r_half_sin <= ppt_pkg::sat_coef($signed(i_cfg_data));
                ppt_pkg::CFG_SHIFT_X:  r_shift_x  <= $signed(i_cfg_data);
                ppt_pkg::CFG_SHIFT_Y:  r_shift_y  <= $signed(i_cfg_data);
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Busy only around reset; otherwise an item may enter every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // ---------------- S0: capture item ----------------
    ppt_pkg::t_side n_s0, r_s0;

    always_comb begin
        n_s0.vld     = start && !r_busy;
        n_s0.quat    = i_cmd;
        n_s0.zero    = 1'b0;
        n_s0.neg     = '0;
        n_s0.pass[0] = i_comp_a;
        n_s0.pass[1] = i_comp_b;
        n_s0.pass[2] = i_comp_c;
        n_s0.pass[3] = i_comp_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else begin
            r_s0 <= n_s0;
        end
    end

    // ---------------- S1: eight 32x32 products ----------------
    // Point uses (cos, sin); quaternion uses (half_cos, half_sin). The first
    // two sums are shared: x' = c0*a - c1*b, y' = c1*a + c0*b.
    ppt_pkg::t_side     r_s1;
    logic signed [31:0] c0, c1, op_a, op_b, op_c, op_d;
    logic signed [63:0] r_prod [8];

    always_comb begin
        c0   = r_s0.quat ? r_half_cos : r_rot_cos;
        c1   = r_s0.quat ? r_half_sin : r_rot_sin;
        op_a = $signed(r_s0.pass[0]);
        op_b = $signed(r_s0.pass[1]);
        op_c = $signed(r_s0.pass[2]);
        op_d = $signed(r_s0.pass[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1 <= r_s0;
        end
        r_prod[0] <= c0 * op_a;
        r_prod[1] <= c1 * op_b;
        r_prod[2] <= c0 * op_b;
        r_prod[3] <= c1 * op_a;
        r_prod[4] <= c0 * op_c;
        r_prod[5] <= c1 * op_d;
        r_prod[6] <= c0 * op_d;
        r_prod[7] <= c1 * op_c;
    end

    // ---------------- S2: exact sums, point rounding ----------------
    ppt_pkg::t_side     r_s2;
    logic signed [63:0] r_p [4];
    logic signed [63:0] n_rx, n_ry;
    logic signed [33:0] r_pt [2];

    always_comb begin
        n_rx = r_prod[0] - r_prod[1] + ppt_pkg::RND_Q30;
        n_ry = r_prod[2] + r_prod[3] + ppt_pkg::RND_Q30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else begin
            r_s2 <= r_s1;
        end
        r_p[0]  <= r_prod[0] - r_prod[1];
        r_p[1]  <= r_prod[2] + r_prod[3];
        r_p[2]  <= r_prod[4] + r_prod[5];
        r_p[3]  <= r_prod[6] - r_prod[7];
        // floor shift by 30 is the top bits of the rounded sum
        r_pt[0] <= n_rx[63:30];
        r_pt[1] <= n_ry[63:30];
    end

    // ---------------- S3: offset and saturate, or magnitudes ----------------
    ppt_pkg::t_side n_s3, r_s3;
    logic [34:0]    sum_x, sum_y;
    logic [63:0]    neg_p [4];
    logic [62:0]    n_m3 [4];
    logic [62:0]    r_m3 [4];

    always_comb begin
        sum_x = {r_pt[0][33], r_pt[0]} + {{3{r_shift_x[31]}}, r_shift_x};
        sum_y = {r_pt[1][33], r_pt[1]} + {{3{r_shift_y[31]}}, r_shift_y};
        for (int i = 0; i < 4; i++) begin
            neg_p[i] = 64'd0 - r_p[i];
            n_m3[i]  = r_p[i][63] ? neg_p[i][62:0] : r_p[i][62:0];
        end
        n_s3 = r_s2;
        if (!r_s2.quat) begin
            n_s3.pass[0] = ppt_pkg::sat35(sum_x);
            n_s3.pass[1] = ppt_pkg::sat35(sum_y);
            n_s3.pass[2] = '0;
            n_s3.pass[3] = '0;
        end else begin
            n_s3.zero = (r_p[0] == '0) && (r_p[1] == '0) && (r_p[2] == '0)
                        && (r_p[3] == '0);
            n_s3.neg  = {r_p[3][63], r_p[2][63], r_p[1][63], r_p[0][63]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else begin
            r_s3 <= n_s3;
        end
        r_m3 <= n_m3;
    end

    // ---------------- S4: leading one of the largest magnitude ----------------
    // The bit length of the OR equals that of the maximum.
    ppt_pkg::t_side r_s4;
    logic [62:0]    m_or;
    logic [5:0]     n_lead, r_lead;
    logic [62:0]    r_m4 [4];

    always_comb begin
        m_or   = r_m3[0] | r_m3[1] | r_m3[2] | r_m3[3];
        n_lead = '0;
        for (int b = 0; b < 63; b++) begin
            if (m_or[b]) begin
                n_lead = 6'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else begin
            r_s4 <= r_s3;
        end
        r_lead <= n_lead;
        r_m4   <= r_m3;
    end

    // ---------------- S5: scale the largest magnitude to [2^30, 2^31) ----------------
    ppt_pkg::t_side r_s5;
    logic [6:0]     sh_amt;
    logic [93:0]    wide [4];
    logic [30:0]    r_mn5 [4];

    always_comb begin
        sh_amt = {1'b0, r_lead} + 7'd1;
        for (int i = 0; i < 4; i++) begin
            wide[i] = {r_m4[i], 31'd0} >> sh_amt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.vld <= 1'b0;
        end else begin
            r_s5 <= r_s4;
        end
        for (int i = 0; i < 4; i++) begin
            r_mn5[i] <= wide[i][30:0];
        end
    end

    // ---------------- S6: squares ----------------
    ppt_pkg::t_side r_s6;
    logic [61:0]    r_sqr [4];
    logic [30:0]    r_mn6 [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.vld <= 1'b0;
        end else begin
            r_s6 <= r_s5;
        end
        for (int i = 0; i < 4; i++) begin
            r_sqr[i] <= r_mn5[i] * r_mn5[i];
        end
        r_mn6 <= r_mn5;
    end

    // ---------------- S7 and root stages ----------------
    ppt_pkg::t_side r_sq_side [0:SQ];
    logic [63:0]    r_sq_op   [0:SQ];
    logic [63:0]    r_sq_res  [0:SQ];
    logic [30:0]    r_sq_m    [0:SQ][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_side[0].vld <= 1'b0;
        end else begin
            r_sq_side[0] <= r_s6;
        end
        r_sq_op[0]  <= {2'b00, r_sqr[0]} + {2'b00, r_sqr[1]}
                     + {2'b00, r_sqr[2]} + {2'b00, r_sqr[3]};
        r_sq_res[0] <= '0;
        r_sq_m[0]   <= r_mn6;
    end

    // One result bit per stage, highest first.
    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [64:0] trial;
        logic        take;

        always_comb begin
            trial = {1'b0, r_sq_res[j]} + {1'b0, BIT};
            take  = {1'b0, r_sq_op[j]} >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_side[j+1].vld <= 1'b0;
            end else begin
                r_sq_side[j+1] <= r_sq_side[j];
            end
            r_sq_op[j+1]  <= take ? r_sq_op[j] - trial[63:0] : r_sq_op[j];
            r_sq_res[j+1] <= take ? (r_sq_res[j] >> 1) + BIT : r_sq_res[j] >> 1;
            r_sq_m[j+1]   <= r_sq_m[j];
        end
    end

    // ---------------- divider: rounded m * 2^29 / n ----------------
    ppt_pkg::t_side r_dv_side [0:DV];
    logic [31:0]    r_dv_n    [0:DV];
    logic [60:0]    r_dv_rem  [0:DV][4];
    logic [DV-1:0]  r_dv_q    [0:DV][4];
    logic [31:0]    root;

    assign root = r_sq_res[SQ][31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_side[0].vld <= 1'b0;
        end else begin
            r_dv_side[0] <= r_sq_side[SQ];
        end
        r_dv_n[0] <= root;
        for (int i = 0; i < 4; i++) begin
            r_dv_rem[0][i] <= {1'b0, r_sq_m[SQ][i], 29'd0} + {30'd0, root[31:1]};
            r_dv_q[0][i]   <= '0;
        end
    end

    // One quotient bit per stage, highest first.
    for (genvar s = 0; s < DV; s++) begin : g_div
        localparam int QB = DV - 1 - s;
        logic [61:0] den;
        logic [3:0]  take;

        always_comb begin
            den = {30'd0, r_dv_n[s]} << QB;
            for (int i = 0; i < 4; i++) begin
                take[i] = {1'b0, r_dv_rem[s][i]} >= den;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_side[s+1].vld <= 1'b0;
            end else begin
                r_dv_side[s+1] <= r_dv_side[s];
            end
            r_dv_n[s+1] <= r_dv_n[s];
            for (int i = 0; i < 4; i++) begin
                r_dv_rem[s+1][i] <= take[i] ? r_dv_rem[s][i] - den[60:0]
                                            : r_dv_rem[s][i];
                r_dv_q[s+1][i]   <= r_dv_q[s][i] | (DV'(take[i]) << QB);
            end
        end
    end

    // ---------------- output register ----------------
    ppt_pkg::t_side last;
    logic [31:0]    n_res [4];
    logic [31:0]    mag   [4];

    assign last = r_dv_side[DV];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag[i]   = {{(32 - DV){1'b0}}, r_dv_q[DV][i]};
            n_res[i] = last.pass[i];
            if (last.quat && !last.zero) begin
                n_res[i] = last.neg[i] ? 32'd0 - mag[i] : mag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= last.vld;
        end
        o_res_a     <= $signed(n_res[0]);
        o_res_b     <= $signed(n_res[1]);
        o_res_c     <= $signed(n_res[2]);
        o_res_d     <= $signed(n_res[3]);
        o_zero_norm <= last.zero;
    end

endmodule

>>> sv/ppt_checker.sv
// Port-level checker of the planar pose transform, bound to the top level.
`include "assert_macros.svh"

module ppt_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_cmd,
    input logic signed [31:0] i_comp_a,
    input logic signed [31:0] i_comp_b,
    input logic signed [31:0] i_comp_c,
    input logic signed [31:0] i_comp_d,
    input logic               o_valid,
    input logic signed [31:0] o_res_a,
    input logic signed [31:0] o_res_b,
    input logic signed [31:0] o_res_c,
    input logic signed [31:0] o_res_d,
    input logic               o_zero_norm
);

    // Every accepted item yields its result after the fixed latency.
    `PPT_ASSERT(a_lat_fwd, i_clk, i_rst_n, (start && !busy) |-> ##(ppt_pkg::LATENCY) o_valid)

    // No result without an item accepted exactly that long ago.
    `PPT_ASSERT_MSG(a_lat_bwd, i_clk, i_rst_n, o_valid |-> $past(start && !busy, ppt_pkg::LATENCY), "result without item")

    // A zero norm hands the input quaternion back unchanged.
    `PPT_ASSERT(a_zero_pass, i_clk, i_rst_n, (o_valid && o_zero_norm) |-> ((o_res_a == $past(i_comp_a, ppt_pkg::LATENCY)) && (o_res_b == $past(i_comp_b, ppt_pkg::LATENCY)) && (o_res_c == $past(i_comp_c, ppt_pkg::LATENCY)) && (o_res_d == $past(i_comp_d, ppt_pkg::LATENCY))))

    // Point results carry zero upper components and no flag.
    `PPT_ASSERT_MSG(a_point_zero, i_clk, i_rst_n, (o_valid && !$past(i_cmd, ppt_pkg::LATENCY)) |-> ((o_res_c == 32'sd0) && (o_res_d == 32'sd0) && !o_zero_norm), "point result not clean")

endmodule

bind planar_pose_transform ppt_port_checker u_ppt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .i_comp_a    (i_comp_a),
    .i_comp_b    (i_comp_b),
    .i_comp_c    (i_comp_c),
    .i_comp_d    (i_comp_d),
    .o_valid     (o_valid),
    .o_res_a     (o_res_a),
    .o_res_b     (o_res_b),
    .o_res_c     (o_res_c),
    .o_res_d     (o_res_d),
    .o_zero_norm (o_zero_norm)
);

>>> verif/ppt_checker.sv
// Checker for the planar pose transform: predicts each item's result and compares.
`timescale 1ns / 100ps

module ppt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_cmd,
    input  logic signed [31:0] i_comp_a,
    input  logic signed [31:0] i_comp_b,
    input  logic signed [31:0] i_comp_c,
    input  logic signed [31:0] i_comp_d,
    input  logic               i_valid,
    input  logic signed [31:0] i_res_a,
    input  logic signed [31:0] i_res_b,
    input  logic signed [31:0] i_res_c,
    input  logic signed [31:0] i_res_d,
    input  logic               i_zero_norm,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_pending,
    output int                 o_fails
);

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic               zn;
    } t_pose_res;

    logic signed [31:0] coef [6];
    t_pose_res          pose_q [$];
    int                 fails;

    assign o_pending = pose_q.size();
    assign o_fails   = fails;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint unsigned int_root(input longint unsigned op);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > op) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (op >= res + bitv) begin
                op  = op - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_pose_res move_point(input logic signed [31:0] x,
                                             input logic signed [31:0] y);
        t_pose_res r;
        longint co;
        longint si;
        longint vx;
        longint vy;
        co = coef[ppt_pkg::CFG_ROT_COS];
        si = coef[ppt_pkg::CFG_ROT_SIN];
        vx = co * longint'(x) - si * longint'(y);
        vy = si * longint'(x) + co * longint'(y);
        r.a  = clamp32(((vx + (64'sd1 <<< 29)) >>> 30)
                       + longint'(coef[ppt_pkg::CFG_SHIFT_X]));
        r.b  = clamp32(((vy + (64'sd1 <<< 29)) >>> 30)
                       + longint'(coef[ppt_pkg::CFG_SHIFT_Y]));
        r.c  = '0;
        r.d  = '0;
        r.zn = 1'b0;
        return r;
    endfunction

    function automatic t_pose_res yaw_quat(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic signed [31:0] c,
                                           input logic signed [31:0] d);
        t_pose_res       r;
        longint          hc;
        longint          hs;
        longint          p [4];
        longint unsigned m [4];
        longint unsigned mx;
        longint unsigned acc;
        longint unsigned n;
        longint unsigned q;
        logic [31:0]     o [4];
        int              k;
        hc = coef[ppt_pkg::CFG_HALF_COS];
        hs = coef[ppt_pkg::CFG_HALF_SIN];
        p[0] = hc * longint'(a) - hs * longint'(b);
        p[1] = hc * longint'(b) + hs * longint'(a);
        p[2] = hc * longint'(c) + hs * longint'(d);
        p[3] = hc * longint'(d) - hs * longint'(c);
        mx = 0;
        for (int i = 0; i < 4; i++) begin
            m[i] = (p[i] < 0) ? longint'(-p[i]) : p[i];
            if (m[i] > mx) mx = m[i];
        end
        // All-zero product: pass the input through and flag it
        if (mx == 0) begin
            r.a  = a;
            r.b  = b;
            r.c  = c;
            r.d  = d;
            r.zn = 1'b1;
            return r;
        end
        k = 0;
        while (k < 64 && (mx >> k) != 0) k++;
        acc = 0;
        for (int i = 0; i < 4; i++) begin
            if (k > 31) m[i] = m[i] >> (k - 31);
            else m[i] = m[i] << (31 - k);
            acc += m[i] * m[i];
        end
        n = int_root(acc);
        for (int i = 0; i < 4; i++) begin
            q = ((m[i] << 29) + (n >> 1)) / n;
            o[i] = (p[i] < 0) ? -q[31:0] : q[31:0];
        end
        r.a  = o[0];
        r.b  = o[1];
        r.c  = o[2];
        r.d  = o[3];
        r.zn = 1'b0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name,
                   $signed(exp_v), exp_v, $signed(act_v), act_v);
            fails++;
        end
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        t_pose_res exp_r;
        logic signed [31:0] v;
        if (!i_rst_n) begin
            coef[ppt_pkg::CFG_ROT_COS]  <= ppt_pkg::ONE_Q30;
            coef[ppt_pkg::CFG_ROT_SIN]  <= '0;
            coef[ppt_pkg::CFG_HALF_COS] <= ppt_pkg::ONE_Q30;
            coef[ppt_pkg::CFG_HALF_SIN] <= '0;
            coef[ppt_pkg::CFG_SHIFT_X]  <= '0;
            coef[ppt_pkg::CFG_SHIFT_Y]  <= '0;
            pose_q.delete();
        end else begin
            // Retire the oldest expectation against each strobed result
            if (i_valid) begin
                if (pose_q.size() == 0) begin
                    $error("result with no item outstanding");
                    fails++;
                end else begin
                    exp_r = pose_q.pop_front();
                    check_field("res_a", exp_r.a, i_res_a);
                    check_field("res_b", exp_r.b, i_res_b);
                    check_field("res_c", exp_r.c, i_res_c);
                    check_field("res_d", exp_r.d, i_res_d);
                    check_field("zero_norm", 32'(exp_r.zn), 32'(i_zero_norm));
                end
            end
            if (i_start && !i_busy) begin
                if (i_cmd) pose_q.push_back(yaw_quat(i_comp_a, i_comp_b, i_comp_c, i_comp_d));
                else pose_q.push_back(move_point(i_comp_a, i_comp_b));
            end
            // Clamp coefficients on write, drop unknown indexes
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= ppt_pkg::CFG_SHIFT_Y) begin
                v = i_cfg_data;
                if (i_cfg_index <= ppt_pkg::CFG_HALF_SIN) begin
                    if (v > ppt_pkg::ONE_Q30) v = ppt_pkg::ONE_Q30;
                    if (v < ppt_pkg::NEG_ONE_Q30) v = ppt_pkg::NEG_ONE_Q30;
                end
                coef[i_cfg_index] <= v;
            end
        end
    end

endmodule

>>> verif/tb_top.sv
// Stimulus and verdict for the planar pose transform testbench.
`timescale 1ns / 100ps

module tb_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               cmd;
    logic signed [31:0] comp_a;
    logic signed [31:0] comp_b;
    logic signed [31:0] comp_c;
    logic signed [31:0] comp_d;
    logic               o_valid;
    logic signed [31:0] o_res_a;
    logic signed [31:0] o_res_b;
    logic signed [31:0] o_res_c;
    logic signed [31:0] o_res_d;
    logic               o_zero_norm;
    logic               cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 pending;
    int                 fails;
    int                 gap_pct;

    // Sample values worth hitting hard: extremes, unity and near-zero
    localparam logic [31:0] EDGE_VALS [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                              32'h1, 32'hffff_ffff, 32'h4000_0000,
                                              32'hc000_0000, 32'h2000_0000};

    planar_pose_transform u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .i_comp_a    (comp_a),
        .i_comp_b    (comp_b),
        .i_comp_c    (comp_c),
        .i_comp_d    (comp_d),
        .o_valid     (o_valid),
        .o_res_a     (o_res_a),
        .o_res_b     (o_res_b),
        .o_res_c     (o_res_c),
        .o_res_d     (o_res_d),
        .o_zero_norm (o_zero_norm),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ppt_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (cmd),
        .i_comp_a    (comp_a),
        .i_comp_b    (comp_b),
        .i_comp_c    (comp_c),
        .i_comp_d    (comp_d),
        .i_valid     (o_valid),
        .i_res_a     (o_res_a),
        .i_res_b     (o_res_b),
        .i_res_c     (o_res_c),
        .i_res_d     (o_res_d),
        .i_zero_norm (o_zero_norm),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_fails     (fails)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest correct run
    initial begin
        #3_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Pick a component: mostly full-range random, sometimes an edge value or small
    function automatic logic [31:0] pick_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return EDGE_VALS[$urandom_range(0, 7)];
        if (sel < 4) return $signed($urandom_range(0, 131072)) - 65536;
        return $urandom;
    endfunction

    // Present one item, hold it until taken, then idle cycle by cycle at random
    task automatic send_item(input logic c, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] cc, input logic [31:0] d);
        start  <= 1'b1;
        cmd    <= c;
        comp_a <= a;
        comp_b <= b;
        comp_c <= cc;
        comp_d <= d;
        @(posedge i_clk iff !busy);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        send_item(1'($urandom_range(0, 1)), pick_comp(), pick_comp(), pick_comp(),
                  pick_comp());
    endtask

    // Drain: drop start and wait until every result is back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write one register; the pipe must be empty
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk iff o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_pose(input logic [31:0] rc, input logic [31:0] rs,
                             input logic [31:0] hc, input logic [31:0] hs,
                             input logic [31:0] sx, input logic [31:0] sy);
        drain();
        write_reg(ppt_pkg::CFG_ROT_COS, rc);
        write_reg(ppt_pkg::CFG_ROT_SIN, rs);
        write_reg(ppt_pkg::CFG_HALF_COS, hc);
        write_reg(ppt_pkg::CFG_HALF_SIN, hs);
        write_reg(ppt_pkg::CFG_SHIFT_X, sx);
        write_reg(ppt_pkg::CFG_SHIFT_Y, sy);
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        cmd       <= 1'b0;
        comp_a    <= '0;
        comp_b    <= '0;
        comp_c    <= '0;
        comp_d    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ppt_pkg::CFG_ROT_COS;
        cfg_data  <= '0;
        gap_pct   = 19;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: identity rotation, no offset
        send_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
        send_item(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h1);
        send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h2000_0000);
        send_item(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h1);

        // 90 degree turn with extreme offsets to force saturation both ways
        load_pose(32'h0, 32'h4000_0000, 32'h2d41_3ccd, 32'h2d41_3ccd,
                  32'h7fff_ffff, 32'h8000_0000);
        send_item(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
        send_item(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(1'b1, 32'h2000_0000, 32'h0, 32'h0, 32'h2000_0000);
        send_item(1'b1, 32'h1, 32'hffff_ffff, 32'h1, 32'hffff_ffff);

        // Out-of-range coefficients clamp; unknown indexes are dropped
        load_pose(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'hffff_0000, 32'h0001_0000);
        write_reg(3'd6, 32'h1234_5678);
        write_reg(3'd7, 32'hffff_ffff);
        send_item(1'b0, 32'h0001_0000, 32'hfffe_0000, 32'h0, 32'h0);
        send_item(1'b1, 32'h2000_0000, 32'he000_0000, 32'h1000_0000, 32'h0);

        // Zero half-angle pair: every quaternion collapses to a zero norm
        load_pose(32'hc000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(1'b1, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 32'hdead_beef);
        send_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);

        // Random part: six settings, idle rate 19% then 66% then none
        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: load_pose(32'hc000_0000, 32'h0, 32'hc000_0000, 32'h0,
                             $urandom, $urandom);
                1: load_pose($urandom_range(0, 32'h8000_0000) - 32'h4000_0000,
                             $urandom_range(0, 32'h8000_0000) - 32'h4000_0000,
                             $urandom, $urandom, $urandom, $urandom);
                default: load_pose($urandom_range(0, 32'h8000_0000) - 32'h4000_0000,
                                   $urandom_range(0, 32'h8000_0000) - 32'h4000_0000,
                                   $urandom_range(0, 32'h8000_0000) - 32'h4000_0000,
                                   $urandom_range(0, 32'h8000_0000) - 32'h4000_0000,
                                   pick_comp(), pick_comp());
            endcase
            gap_pct = (seg < 2) ? 19 : (seg < 4) ? 66 : 0;
            for (int n = 0; n < 300; n++) begin
                // Hold off once mid-run until every result is back
                if (seg == 2 && n == 150) drain();
                send_random();
            end
        end

        // Wait out the pipe, then a margin for any stray result
        drain();
        repeat (ppt_pkg::LATENCY + 20) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/ppt_pkg.sv
sv/planar_pose_transform.sv
sv/ppt_checker.sv
verif/ppt_checker.sv
verif/tb_top.sv
